// ----- sv/abfp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abfp_pkg
// Shared types, widths and constants of the adaptive batch flush policy block.
// ----------------------------------------------------------------------------
package abfp_pkg;

  // field widths
  localparam int ChanW    = 3;
  localparam int HandleW  = 32;
  localparam int TimeW    = 32;
  localparam int CntW     = 17;
  localparam int ThrW     = 16;
  localparam int WinW     = 12;
  localparam int FacW     = 5;
  localparam int ActW     = 2;

  // per-channel state
  localparam int NumChannels = 8;
  localparam int ChIdxW      = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  // command queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // divider: quotient bits resolved per cycle
  localparam int DivBitsPerCycle = 4;
  localparam int DivSteps        = ThrW / DivBitsPerCycle;
  localparam int DivCntW         = (DivSteps > 1) ? $clog2(DivSteps) : 1;

  // products
  localparam int TfW   = ThrW + FacW;   // threshold times factor
  localparam int ProdW = TfW + WinW;    // times window
  localparam int QwW   = ThrW + WinW;   // quotient times window

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [ThrW-1:0] ThrResetVal = ThrW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FWD_EN  = 3'd0,
    CFG_WINDOW  = 3'd1,
    CFG_FACTOR  = 3'd2,
    CFG_THR_MAX = 3'd3,
    CFG_THR_MIN = 3'd4
  } cfg_reg_e;

  typedef enum logic [ActW-1:0] {
    ACT_DROP = 2'd0,
    ACT_HOLD = 2'd1,
    ACT_SEND = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    OP_DROP   = 2'd0,
    OP_FLUSH  = 2'd1,
    OP_PACKET = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_MUL  = 2'd2,
    ST_FIN  = 2'd3
  } back_state_e;

  typedef struct packed {
    logic             fwd_en;
    logic [WinW-1:0]  window;
    logic [FacW-1:0]  factor;
    logic [ThrW-1:0]  thr_max;
    logic [ThrW-1:0]  thr_min;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic [ChanW-1:0]   chan;
    logic [ChIdxW-1:0]  ch;
    logic [HandleW-1:0] handle;
    logic [TimeW-1:0]   now;
  } cmd_t;

  typedef struct packed {
    action_e            action;
    logic [ChanW-1:0]   chan;
    logic [HandleW-1:0] head;
    logic [CntW-1:0]    count;
    logic [ThrW-1:0]    thr;
  } result_t;

  typedef struct packed {
    logic            start;
    logic [ThrW-1:0] dividend;
    logic [FacW-1:0] divisor;
  } div_req_t;

endpackage : abfp_pkg
`default_nettype wire

// ----- sv/adaptive_batch_flush_policy_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_batch_flush_policy_top
// Per-channel packet batching with a threshold that adapts to arrival rate.
// ----------------------------------------------------------------------------
// Every accepted transaction yields exactly one result transaction, in order.
// Transactions pass a two-entry command queue into the execution back end,
// which handles an item whose channel window stays open straight from idle
// once the output register is free, and takes an item that closes its window
// through these steps: read the channel and start the divider, divide the
// threshold by the growth factor, take the quotient, one multiply stage that
// replaces the packet-rate divide by compares, and a write-back that waits
// while the output register stays stalled. Results sit in an output register,
// so new items keep entering the queue while a result is stalled.
// Channel state resets immediately (no clearing pass); thresholds reset to one.
// Configuration writes are always ready and must only be issued while idle.
module adaptive_batch_flush_policy_top import abfp_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                req_type_i,
  input  wire logic [ChanW-1:0]    channel_i,
  input  wire logic [HandleW-1:0]  node_handle_i,
  input  wire logic [TimeW-1:0]    now_sec_i,
  // output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [ActW-1:0]          action_o,
  output logic [ChanW-1:0]         out_channel_o,
  output logic [HandleW-1:0]       batch_head_o,
  output logic [CntW-1:0]          batch_count_o,
  output logic [ThrW-1:0]          threshold_now_o,
  // configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  cmd_t    front_cmd;
  cmd_t    q_cmd;
  logic    push;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  result_t result;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fwd_en  <= 1'b1;
      cfg_q.window  <= WinW'(1);
      cfg_q.factor  <= FacW'(2);
      cfg_q.thr_max <= ThrW'(1024);
      cfg_q.thr_min <= ThrW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FWD_EN:  cfg_q.fwd_en  <= cfg_data_i[0];
        CFG_WINDOW:  cfg_q.window  <= cfg_data_i[WinW-1:0];
        CFG_FACTOR:  cfg_q.factor  <= cfg_data_i[FacW-1:0];
        CFG_THR_MAX: cfg_q.thr_max <= cfg_data_i[ThrW-1:0];
        CFG_THR_MIN: cfg_q.thr_min <= cfg_data_i[ThrW-1:0];
        default: begin
        end
      endcase
    end
  end

  // front end
  abfp_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .channel_i     (channel_i),
    .node_handle_i (node_handle_i),
    .now_sec_i     (now_sec_i),
    .fwd_en_i      (cfg_q.fwd_en),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  // command queue
  abfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // back end
  abfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign action_o        = result.action;
  assign out_channel_o   = result.chan;
  assign batch_head_o    = result.head;
  assign batch_count_o   = result.count;
  assign threshold_now_o = result.thr;

endmodule : adaptive_batch_flush_policy_top
`default_nettype wire

// ----- sv/abfp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abfp_front
// Accepts input transactions, classifies them into drop, flush or packet
// commands and pushes them into the command queue.
// ----------------------------------------------------------------------------
module abfp_front import abfp_pkg::*; (
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               req_type_i,
  input  wire logic [ChanW-1:0]   channel_i,
  input  wire logic [HandleW-1:0] node_handle_i,
  input  wire logic [TimeW-1:0]   now_sec_i,
  input  wire logic               fwd_en_i,
  input  wire logic               q_full_i,
  output logic                    push_o,
  output cmd_t                    cmd_o
);

  // stall while the queue has no room
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // classify the transaction
  always_comb begin
    if (!fwd_en_i) begin
      cmd_o.op = OP_DROP;
    end else if (req_type_i) begin
      cmd_o.op = OP_FLUSH;
    end else begin
      cmd_o.op = OP_PACKET;
    end
    cmd_o.chan   = channel_i;
    cmd_o.ch     = ChIdxW'(channel_i % NumChannels);
    cmd_o.handle = node_handle_i;
    cmd_o.now    = now_sec_i;
  end

endmodule : abfp_front
`default_nettype wire

// ----- sv/abfp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abfp_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module abfp_queue import abfp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule : abfp_queue
`default_nettype wire

// ----- sv/abfp_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abfp_div
// Restoring divider of the threshold by the growth factor, DivBitsPerCycle
// quotient bits per cycle.
// ----------------------------------------------------------------------------
module abfp_div import abfp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire div_req_t   req_i,
  output logic            done_o,
  output logic [ThrW-1:0] quo_o
);

  logic [FacW-1:0]    rem_q, rem_d;
  logic [ThrW-1:0]    quo_q, quo_d;
  logic [FacW-1:0]    dvs_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;

  assign done_o = done_q;
  assign quo_o  = quo_q;

  // several compare-subtract steps per cycle
  always_comb begin
    logic [FacW:0] part;
    rem_d = rem_q;
    quo_d = quo_q;
    part  = '0;
    for (int i = 0; i < DivBitsPerCycle; i++) begin
      part  = {rem_d, quo_d[ThrW-1]};
      quo_d = {quo_d[ThrW-2:0], 1'b0};
      if (part >= {1'b0, dvs_q}) begin
        part     = part - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
      rem_d = part[FacW-1:0];
    end
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

endmodule : abfp_div
`default_nettype wire

// ----- sv/abfp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abfp_back
// Carries out queued commands: per-channel batching, batch send decision and
// threshold adaptation at the end of each measurement window.
// ----------------------------------------------------------------------------
module abfp_back import abfp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output result_t   result_o
);

  // per-channel state
  logic [CntW-1:0]    pend_q  [NumChannels];
  logic [HandleW-1:0] head_q  [NumChannels];
  logic [ThrW-1:0]    thr_q   [NumChannels];
  logic [TimeW-1:0]   wp_q    [NumChannels];
  logic [TimeW-1:0]   start_q [NumChannels];

  back_state_e state_q, state_d;

  // working registers of a closing window
  logic [ChIdxW-1:0]  w_ch_q;
  logic [ChanW-1:0]   w_chan_q;
  logic [TimeW-1:0]   w_now_q;
  logic [ThrW-1:0]    w_t_q;
  logic [TimeW-1:0]   w_wp_q;
  logic               w_send_q;
  logic [HandleW-1:0] w_head_q;
  logic [CntW-1:0]    w_count_q;
  logic [TfW-1:0]     tf_q;
  logic [ProdW-1:0]   prod_q;
  logic [QwW-1:0]     qw_q;

  // output register
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  logic [WinW-1:0]    win_eff;
  logic [FacW-1:0]    fac_eff;
  logic [ThrW-1:0]    t0, t1;
  logic [CntW-1:0]    p0, p1;
  logic [HandleW-1:0] h0, h1;
  logic [TimeW-1:0]   wp0, wp1;
  logic [TimeW-1:0]   s0;
  logic               is_drop;
  logic               send;
  logic               closing;
  logic               out_free;
  logic               item_wr;
  logic               open_wr;
  logic               fin_wr;
  logic               load_idle;
  logic               grow;
  logic               shrink;
  logic [ThrW-1:0]    t_new;
  logic [ThrW-1:0]    div_quo;
  logic               div_done;
  div_req_t           div_req;
  result_t            res_d;

  // zero window and zero factor act as one
  assign win_eff = (cfg_i.window == '0) ? WinW'(1) : cfg_i.window;
  assign fac_eff = (cfg_i.factor == '0) ? FacW'(1) : cfg_i.factor;

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_drop  = (cmd_i.op == OP_DROP);

  // read-modify of the channel named by the queue head
  always_comb begin
    t0  = thr_q[cmd_i.ch];
    p0  = pend_q[cmd_i.ch];
    h0  = head_q[cmd_i.ch];
    wp0 = wp_q[cmd_i.ch];
    s0  = start_q[cmd_i.ch];
    t1  = t0;
    p1  = p0;
    h1  = h0;
    wp1 = wp0;
    if (cmd_i.op == OP_FLUSH) begin
      t1 = '0;
    end else if (cmd_i.op == OP_PACKET) begin
      if (p0 == '0) begin
        h1 = cmd_i.handle;
      end
      p1  = p0 + 1'b1;
      wp1 = wp0 + 1'b1;
    end
    send    = (p1 > CntW'(t1));
    closing = ((TimeW+1)'(s0) + (TimeW+1)'(win_eff)) < (TimeW+1)'(cmd_i.now);
  end

  // window close comparisons, without a divider on the packet count
  always_comb begin
    grow   = (ProdW+1)'(w_wp_q) >= ((ProdW+1)'(prod_q) + (ProdW+1)'(win_eff));
    shrink = w_wp_q < TimeW'(qw_q);
    if (grow) begin
      t_new = (tf_q > TfW'(cfg_i.thr_max)) ? cfg_i.thr_max : tf_q[ThrW-1:0];
    end else if (shrink) begin
      t_new = (div_quo < cfg_i.thr_min) ? cfg_i.thr_min : div_quo;
    end else begin
      t_new = w_t_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && !is_drop && closing) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control strobes
  always_comb begin
    cmd_pop_o = 1'b0;
    item_wr   = 1'b0;
    open_wr   = 1'b0;
    load_idle = 1'b0;
    fin_wr    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (is_drop) begin
            cmd_pop_o = out_free;
            load_idle = out_free;
          end else if (closing) begin
            cmd_pop_o = 1'b1;
            item_wr   = 1'b1;
          end else begin
            cmd_pop_o = out_free;
            item_wr   = out_free;
            open_wr   = out_free;
            load_idle = out_free;
          end
        end
      end
      ST_FIN: begin
        fin_wr = out_free;
      end
      default: begin
        cmd_pop_o = 1'b0;
      end
    endcase
  end

  // divider request on a closing window
  always_comb begin
    div_req.start    = item_wr && !open_wr;
    div_req.dividend = t1;
    div_req.divisor  = fac_eff;
  end

  abfp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // result selection
  always_comb begin
    if (fin_wr) begin
      res_d.action = w_send_q ? ACT_SEND : ACT_HOLD;
      res_d.chan   = w_chan_q;
      res_d.head   = w_head_q;
      res_d.count  = w_count_q;
      res_d.thr    = t_new;
    end else if (is_drop) begin
      res_d.action = ACT_DROP;
      res_d.chan   = cmd_i.chan;
      res_d.head   = '0;
      res_d.count  = '0;
      res_d.thr    = t0;
    end else begin
      res_d.action = send ? ACT_SEND : ACT_HOLD;
      res_d.chan   = cmd_i.chan;
      res_d.head   = send ? h1 : '0;
      res_d.count  = send ? p1 : '0;
      res_d.thr    = t1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_idle || fin_wr) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // channel state with reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        pend_q[i]  <= '0;
        thr_q[i]   <= ThrResetVal;
        wp_q[i]    <= '0;
        start_q[i] <= '0;
      end
    end else begin
      if (item_wr) begin
        pend_q[cmd_i.ch] <= send ? '0 : p1;
      end
      if (open_wr) begin
        thr_q[cmd_i.ch] <= t1;
        wp_q[cmd_i.ch]  <= wp1;
      end
      if (fin_wr) begin
        thr_q[w_ch_q]   <= t_new;
        wp_q[w_ch_q]    <= '0;
        start_q[w_ch_q] <= w_now_q;
      end
    end
  end

  // batch head handles, valid once written
  always_ff @(posedge clk_i) begin
    if (item_wr && !send) begin
      head_q[cmd_i.ch] <= h1;
    end
  end

  // working registers and products
  always_ff @(posedge clk_i) begin
    if (div_req.start) begin
      w_ch_q    <= cmd_i.ch;
      w_chan_q  <= cmd_i.chan;
      w_now_q   <= cmd_i.now;
      w_t_q     <= t1;
      w_wp_q    <= wp1;
      w_send_q  <= send;
      w_head_q  <= send ? h1 : '0;
      w_count_q <= send ? p1 : '0;
      tf_q      <= TfW'(t1) * TfW'(fac_eff);
    end
    prod_q <= ProdW'(tf_q) * ProdW'(win_eff);
    qw_q   <= QwW'(div_quo) * QwW'(win_eff);
  end

  always_ff @(posedge clk_i) begin
    if (load_idle || fin_wr) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule : abfp_back
`default_nettype wire

// ----- sv/abfp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abfp_checker
// Port-level checks on the result channel of the batch flush policy block.
// ----------------------------------------------------------------------------
module abfp_checker import abfp_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_i,
  input wire logic               out_stall_i,
  input wire logic [ActW-1:0]    action_i,
  input wire logic [HandleW-1:0] batch_head_i,
  input wire logic [CntW-1:0]    batch_count_i,
  input wire logic [ThrW-1:0]    threshold_now_i
);

  // a stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(action_i) &&
      $stable(batch_head_i) && $stable(batch_count_i) && $stable(threshold_now_i))
    else $error("stalled result changed");

  // no batch fields unless a batch is sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && action_i != ACT_SEND |-> batch_count_i == '0 && batch_head_i == '0)
    else $error("batch fields set without a send");

  // a sent batch carries at least one packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && action_i == ACT_SEND |-> batch_count_i != '0)
    else $error("empty batch sent");

  // no result right after reset release
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result present after reset");

endmodule : abfp_checker

bind adaptive_batch_flush_policy_top abfp_checker u_abfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .action_i        (action_o),
  .batch_head_i    (batch_head_o),
  .batch_count_i   (batch_count_o),
  .threshold_now_i (threshold_now_o)
);
`default_nettype wire

// ----- tb/adaptive_batch_flush_policy_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_batch_flush_policy_top_tb
// Drives packets and flush requests into the batch flush policy block and
// checks every result against a typed table row or an in-bench model of the
// per-channel batching and rate-adaptive thresholds, both ports idle at random.
// ----------------------------------------------------------------------------
module adaptive_batch_flush_policy_top_tb;
  import abfp_pkg::*;

  localparam logic ReqPacket  = 1'b0;
  localparam logic ReqFlush   = 1'b1;
  localparam int   NumPhases  = 12;
  localparam int   PhaseItems = 83;
  localparam int   LongHold   = 40;

  // one row of the directed table: a register write or an item
  typedef struct packed {
    logic               is_cfg;
    cfg_reg_e           reg_idx;
    logic [15:0]        data;
    logic               req;
    logic [ChanW-1:0]   chan;
    logic [HandleW-1:0] handle;
    logic [TimeW-1:0]   now;
    logic               typed;
    action_e            act;
    logic [HandleW-1:0] head;
    logic [CntW-1:0]    cnt;
    logic [ThrW-1:0]    thr;
  } dir_row_t;

  localparam int NumRows = 28;
  localparam dir_row_t DirRows [NumRows] = '{
    // opening batches at reset settings
    '{1'b0, CFG_FWD_EN, 16'd0, ReqPacket, 3'd0, 32'h0, 32'h0,
      1'b1, ACT_HOLD, 32'h0, 17'd0, 16'd1},
    '{1'b0, CFG_FWD_EN, 16'd0, ReqPacket, 3'd0, 32'hFFFF_FFFF, 32'h0,
      1'b1, ACT_SEND, 32'h0, 17'd2, 16'd1},
    '{1'b0, CFG_FWD_EN, 16'd0, ReqPacket, 3'd1, 32'hFFFF_FFFF, 32'h0,
      1'b1, ACT_HOLD, 32'h0, 17'd0, 16'd1},
    '{1'b0, CFG_FWD_EN, 16'd0, ReqFlush, 3'd1, 32'h0, 32'h0,
      1'b1, ACT_SEND, 32'hFFFF_FFFF, 17'd1, 16'd0},
    '{1'b0, CFG_FWD_EN, 16'd0, ReqFlush, 3'd2, 32'h0, 32'h0,
      1'b1, ACT_HOLD, 32'h0, 17'd0, 16'd0},
    '{1'b0, CFG_FWD_EN, 16'd0, ReqPacket, 3'd2, 32'h1234_5678, 32'h0,
      1'b1, ACT_SEND, 32'h1234_5678, 17'd1, 16'd0},
    // time at its top, window closes without wrap
    '{1'b0, CFG_FWD_EN, 16'd0, ReqPacket, 3'd7, 32'hA5A5_A5A5, 32'hFFFF_FFFF,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    '{1'b0, CFG_FWD_EN, 16'd0, ReqFlush, 3'd7, 32'h0, 32'hFFFF_FFFF,
      1'b1, ACT_SEND, 32'hA5A5_A5A5, 17'd1, 16'd0},
    // threshold growth on a busy window
    '{1'b0, CFG_FWD_EN, 16'd0, ReqPacket, 3'd3, 32'h11, 32'd1,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    '{1'b0, CFG_FWD_EN, 16'd0, ReqPacket, 3'd3, 32'h22, 32'd1,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    '{1'b0, CFG_FWD_EN, 16'd0, ReqPacket, 3'd3, 32'h33, 32'd1,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    '{1'b0, CFG_FWD_EN, 16'd0, ReqPacket, 3'd3, 32'h44, 32'd3,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    // forwarding off drops packets and flushes alike
    '{1'b1, CFG_FWD_EN, 16'd0, ReqPacket, 3'd0, 32'h0, 32'h0,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    '{1'b0, CFG_FWD_EN, 16'd0, ReqPacket, 3'd0, 32'h5, 32'd100,
      1'b1, ACT_DROP, 32'h0, 17'd0, 16'd1},
    '{1'b0, CFG_FWD_EN, 16'd0, ReqFlush, 3'd4, 32'h0, 32'd100,
      1'b1, ACT_DROP, 32'h0, 17'd0, 16'd1},
    '{1'b1, CFG_FWD_EN, 16'd1, ReqPacket, 3'd0, 32'h0, 32'h0,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    // zero window and zero factor
    '{1'b1, CFG_WINDOW, 16'd0, ReqPacket, 3'd0, 32'h0, 32'h0,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    '{1'b1, CFG_FACTOR, 16'd0, ReqPacket, 3'd0, 32'h0, 32'h0,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    '{1'b0, CFG_FWD_EN, 16'd0, ReqPacket, 3'd5, 32'h0BAD_CAFE, 32'd0,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    '{1'b0, CFG_FWD_EN, 16'd0, ReqPacket, 3'd5, 32'h600D_F00D, 32'd0,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    '{1'b0, CFG_FWD_EN, 16'd0, ReqPacket, 3'd5, 32'h7777_0001, 32'd2,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    // limits at their extremes, stored thresholds untouched
    '{1'b1, CFG_THR_MIN, 16'd0, ReqPacket, 3'd0, 32'h0, 32'h0,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    '{1'b1, CFG_FACTOR, 16'd16, ReqPacket, 3'd0, 32'h0, 32'h0,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    '{1'b1, CFG_WINDOW, 16'd3600, ReqPacket, 3'd0, 32'h0, 32'h0,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    '{1'b1, CFG_THR_MAX, 16'hFFFF, ReqPacket, 3'd0, 32'h0, 32'h0,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    '{1'b0, CFG_FWD_EN, 16'd0, ReqPacket, 3'd6, 32'h0F0F_0F0F, 32'd0,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    '{1'b0, CFG_FWD_EN, 16'd0, ReqPacket, 3'd6, 32'hF0F0_F0F0, 32'd4000,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0},
    '{1'b0, CFG_FWD_EN, 16'd0, ReqPacket, 3'd4, 32'h8000_0001, 32'd8000,
      1'b0, ACT_DROP, 32'h0, 17'd0, 16'd0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                req_type_i = 1'b0;
  logic [ChanW-1:0]    channel_i = '0;
  logic [HandleW-1:0]  node_handle_i = '0;
  logic [TimeW-1:0]    now_sec_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [ActW-1:0]     action_o;
  logic [ChanW-1:0]    out_channel_o;
  logic [HandleW-1:0]  batch_head_o;
  logic [CntW-1:0]     batch_count_o;
  logic [ThrW-1:0]     threshold_now_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // model copy of the settings
  logic            fwd_on   = 1'b1;
  logic [WinW-1:0] win_len  = 12'd1;
  logic [FacW-1:0] grow_fac = 5'd2;
  logic [ThrW-1:0] thr_hi   = 16'd1024;
  logic [ThrW-1:0] thr_lo   = 16'd1;

  // model copy of the per-channel state
  logic [HandleW-1:0] ch_head      [NumChannels];
  logic [CntW-1:0]    ch_pending   [NumChannels];
  logic [ThrW-1:0]    ch_thr       [NumChannels];
  logic [31:0]        ch_win_pkts  [NumChannels];
  logic [TimeW-1:0]   ch_win_start [NumChannels];

  result_t awaited_results[$];
  int      err_cnt = 0;
  logic    quiet_run = 1'b0;
  logic    long_hold_req = 1'b0;

  adaptive_batch_flush_policy_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .channel_i       (channel_i),
    .node_handle_i   (node_handle_i),
    .now_sec_i       (now_sec_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .action_o        (action_o),
    .out_channel_o   (out_channel_o),
    .batch_head_o    (batch_head_o),
    .batch_count_o   (batch_count_o),
    .threshold_now_o (threshold_now_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL adaptive_batch_flush_policy_top");
    $finish;
  end

  initial begin
    for (int i = 0; i < NumChannels; i++) begin
      ch_head[i]      = '0;
      ch_pending[i]   = '0;
      ch_thr[i]       = 16'd1;
      ch_win_pkts[i]  = '0;
      ch_win_start[i] = '0;
    end
  end

  task automatic flag_error(input string what);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
  endtask

  // batching and threshold adaptation for one accepted item
  function automatic result_t forecast_batch(input logic req, input logic [ChanW-1:0] chan,
                                             input logic [HandleW-1:0] handle,
                                             input logic [TimeW-1:0] now);
    result_t     r;
    int          ch;
    logic [63:0] win64;
    logic [63:0] fac64;
    logic [63:0] t64;
    logic [63:0] rate64;
    ch       = int'(chan) % NumChannels;
    r.action = ACT_HOLD;
    r.chan   = chan;
    r.head   = '0;
    r.count  = '0;
    if (!fwd_on) begin
      r.action = ACT_DROP;
    end else begin
      if (req == ReqFlush) begin
        ch_thr[ch] = '0;
      end else begin
        if (ch_pending[ch] == '0) ch_head[ch] = handle;
        ch_pending[ch]  = ch_pending[ch] + 1'b1;
        ch_win_pkts[ch] = ch_win_pkts[ch] + 1'b1;
      end
      // send once the batch exceeds the threshold
      if (ch_pending[ch] > {1'b0, ch_thr[ch]}) begin
        r.action       = ACT_SEND;
        r.head         = ch_head[ch];
        r.count        = ch_pending[ch];
        ch_pending[ch] = '0;
        ch_head[ch]    = '0;
      end
      // window end: grow or shrink by the factor, then clamp
      win64 = (win_len == '0) ? 64'd1 : 64'(win_len);
      fac64 = (grow_fac == '0) ? 64'd1 : 64'(grow_fac);
      t64   = 64'(ch_thr[ch]);
      if (64'(ch_win_start[ch]) + win64 < 64'(now)) begin
        rate64 = 64'(ch_win_pkts[ch]) / win64;
        if (rate64 > t64 * fac64) begin
          t64 = t64 * fac64;
          if (t64 > 64'(thr_hi)) t64 = 64'(thr_hi);
        end else if (rate64 < t64 / fac64) begin
          t64 = t64 / fac64;
          if (t64 < 64'(thr_lo)) t64 = 64'(thr_lo);
        end
        ch_thr[ch]       = t64[ThrW-1:0];
        ch_win_pkts[ch]  = '0;
        ch_win_start[ch] = now;
      end
    end
    r.thr = ch_thr[ch];
    return r;
  endfunction

  // register write, only once every awaited result is back
  task automatic write_setting(input cfg_reg_e idx, input logic [15:0] value);
    in_valid_i = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_FWD_EN:  fwd_on   = value[0];
      CFG_WINDOW:  win_len  = value[WinW-1:0];
      CFG_FACTOR:  grow_fac = value[FacW-1:0];
      CFG_THR_MAX: thr_hi   = value;
      CFG_THR_MIN: thr_lo   = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // offer one item, called at a falling edge and returning at one
  task automatic send_item(input logic req, input logic [ChanW-1:0] chan,
                           input logic [HandleW-1:0] handle, input logic [TimeW-1:0] now,
                           input logic use_typed, input result_t typed_res);
    result_t predicted;
    in_valid_i    = 1'b1;
    req_type_i    = req;
    channel_i     = chan;
    node_handle_i = handle;
    now_sec_i     = now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = forecast_batch(req, chan, handle, now);
    awaited_results.push_back(use_typed ? typed_res : predicted);
    @(negedge clk_i);
    if (!quiet_run && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  // receiver stall: random bursts, plus one long hold-off on request
  initial begin
    int hold_cnt;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_stall_i = 1'b1;
        for (hold_cnt = 0; hold_cnt < LongHold; hold_cnt++) @(negedge clk_i);
        long_hold_req = 1'b0;
        out_stall_i   = 1'b0;
      end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        flag_error("result transaction with nothing awaited");
      end else begin
        want = awaited_results.pop_front();
        if (action_o !== want.action || out_channel_o !== want.chan ||
            batch_head_o !== want.head || batch_count_o !== want.count ||
            threshold_now_o !== want.thr) begin
          flag_error($sformatf({"expected act %0d ch %0d head %h cnt %0d thr %0d, ",
                                "got act %0d ch %0d head %h cnt %0d thr %0d"},
                               want.action, want.chan, want.head, want.count, want.thr,
                               action_o, out_channel_o, batch_head_o, batch_count_o,
                               threshold_now_o));
        end
      end
    end
  end

  // stimulus
  initial begin
    dir_row_t        row;
    result_t         typed_res;
    logic            s_fwd;
    logic [WinW-1:0] s_win;
    logic [FacW-1:0] s_fac;
    logic [ThrW-1:0] s_max;
    logic [ThrW-1:0] s_min;
    logic [31:0]     cur_now;
    logic [31:0]     eff_win;
    logic [ChanW-1:0] chan;
    logic            req;
    int              pace;
    int              sel;
    int              drain_cycles;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    for (int r = 0; r < NumRows; r++) begin
      row = DirRows[r];
      if (row.is_cfg) begin
        write_setting(row.reg_idx, row.data);
      end else begin
        typed_res.action = row.act;
        typed_res.chan   = row.chan;
        typed_res.head   = row.head;
        typed_res.count  = row.cnt;
        typed_res.thr    = row.thr;
        send_item(row.req, row.chan, row.handle, row.now, row.typed, typed_res);
      end
    end

    // random phases, each under its own settings
    for (int phase = 0; phase < NumPhases; phase++) begin
      s_fwd = ($urandom_range(0, 7) != 0);
      s_win = ($urandom_range(0, 5) != 0) ? WinW'($urandom_range(1, 4))
                                          : WinW'($urandom_range(1, 3600));
      s_fac = FacW'($urandom_range(2, 16));
      case ($urandom_range(0, 3))
        0:       s_max = ThrW'($urandom_range(1, 16));
        1:       s_max = 16'd1024;
        2:       s_max = 16'hFFFF;
        default: s_max = ThrW'($urandom_range(1, 65535));
      endcase
      s_min = ($urandom_range(0, 5) == 0) ? ThrW'($urandom_range(0, 65535))
                                          : ThrW'($urandom_range(0, 3));
      case (phase)
        0: begin
          s_fwd = 1'b1; s_win = 12'd3600; s_fac = 5'd16; s_max = 16'hFFFF; s_min = 16'd0;
        end
        1: begin
          s_fwd = 1'b1; s_win = 12'd1; s_fac = 5'd2; s_max = 16'd1; s_min = 16'd0;
        end
        2: s_fwd = 1'b0;
        default: ;
      endcase
      write_setting(CFG_FWD_EN, 16'(s_fwd));
      write_setting(CFG_WINDOW, 16'(s_win));
      write_setting(CFG_FACTOR, 16'(s_fac));
      write_setting(CFG_THR_MAX, s_max);
      write_setting(CFG_THR_MIN, s_min);

      quiet_run = (phase == NumPhases - 1);
      if (phase == 3) long_hold_req = 1'b1;
      case ($urandom_range(0, 3))
        0:       pace = 1;
        1:       pace = 2;
        2:       pace = 8;
        default: pace = 32;
      endcase
      eff_win = (s_win == '0) ? 32'd1 : 32'(s_win);
      cur_now = 32'(phase) * 32'h1400_0000 + 32'($urandom_range(0, 32'h00FF_FFFF));

      for (int n = 0; n < PhaseItems; n++) begin
        // time moves on in small steps, now and then a jump
        if ($urandom_range(0, 255) == 0) begin
          cur_now = cur_now + 32'($urandom_range(0, 1 << 20));
        end else if ($urandom_range(0, pace - 1) == 0) begin
          cur_now = cur_now + 32'($urandom_range(1, eff_win));
        end
        // flushes mostly on channels already flushed to zero
        req = ($urandom_range(0, 19) == 0) ? ReqFlush : ReqPacket;
        sel = $urandom_range(0, 19);
        if (req == ReqFlush) begin
          if (sel == 0)      chan = ChanW'($urandom_range(0, 7));
          else if (sel < 7)  chan = 3'd1;
          else if (sel < 13) chan = 3'd2;
          else               chan = 3'd7;
        end else begin
          if (sel < 6)       chan = 3'd0;
          else if (sel < 11) chan = 3'd3;
          else               chan = ChanW'($urandom_range(0, 7));
        end
        send_item(req, chan, $urandom, cur_now, 1'b0, '0);
      end
    end

    // wind down
    in_valid_i   = 1'b0;
    drain_cycles = 0;
    while (awaited_results.size() != 0 && drain_cycles < 20000) begin
      @(negedge clk_i);
      drain_cycles++;
    end
    if (awaited_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", awaited_results.size()));
    end
    repeat (20) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS adaptive_batch_flush_policy_top");
    end else begin
      $display("FAIL adaptive_batch_flush_policy_top");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/abfp_pkg.sv
sv/abfp_front.sv
sv/abfp_queue.sv
sv/abfp_div.sv
sv/abfp_back.sv
sv/adaptive_batch_flush_policy_top.sv
sv/abfp_checker.sv
tb/adaptive_batch_flush_policy_top_tb.sv
